>>> src/bst_pkg.sv
// Shared types and codes for the bounded set table.
package bst_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_ALREADY   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_RESP  = 2'd3
    } t_state;

endpackage

>>> src/bounded_set_table_core.sv
// Bounded set table: sequencer, compare unit and count around the entry store.
//
// Holds up to MAX_ELEMENTS distinct 32-bit values in insertion order.
// Input channel (i_in_valid / o_in_stall) carries an opcode and a value:
// clear, add, remove or membership query. Each transaction gives exactly
// one result on the output channel (o_out_valid / i_out_stall) with the
// prior presence of the value, a status code and the count afterwards.
// One item is worked on at a time; o_in_stall stays high until it ends.
// The scan reads one entry per cycle, compares it in the cycle after, and
// stops on a hit. A remove that hits then shifts each later entry down one
// per cycle and drops the count. The result register is then loaded; the
// next transaction is taken the cycle after.
// If the receiver stalls, the result holds in the output register and a
// new item may still be taken and worked on; it waits before its own
// result load until the register is free.
// Reset clears the count and the control state; the store is not cleared,
// since no entry at or above the count is ever read.
module bounded_set_table_core #(
    parameter int MAX_ELEMENTS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_present,
    output logic [1:0]         o_status,
    output logic [7:0]         o_count
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);

    bst_pkg::t_state  r_state, n_state;
    bst_pkg::t_opcode r_op;
    logic [31:0]      r_value;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_addr, n_rd_addr;
    logic [CW-1:0]    r_pend_addr, n_pend_addr;
    logic             r_pend, n_pend;
    logic             r_present, n_present;
    bst_pkg::t_status r_status, n_status;

    logic             r_out_valid;
    logic             r_out_present;
    bst_pkg::t_status r_out_status;
    logic [CW-1:0]    r_out_count;

    logic             ram_we;
    logic [CW-1:0]    ram_waddr;
    logic [31:0]      ram_wdata;
    logic             ram_re;
    logic [31:0]      ram_rdata;

    logic             in_fire;
    logic             out_free;
    logic             hit;
    logic             more;
    logic [CW+7:0]    count_ext;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign hit      = r_pend && (ram_rdata == r_value);
    assign more     = r_rd_addr < r_count;

    bst_ram #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[IW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bst_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = bst_pkg::S_SCAN;
                end
            end
            bst_pkg::S_SCAN: begin
                if (hit && r_op == bst_pkg::OP_REMOVE) begin
                    n_state = bst_pkg::S_SHIFT;
                end else if (hit || !more) begin
                    n_state = bst_pkg::S_RESP;
                end
            end
            bst_pkg::S_SHIFT: begin
                if (!r_pend && !more) begin
                    n_state = bst_pkg::S_RESP;
                end
            end
            bst_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = bst_pkg::S_IDLE;
                end
            end
            default: n_state = bst_pkg::S_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_pend_addr = r_pend_addr;
        n_pend      = 1'b0;
        n_present   = r_present;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = r_count;
        ram_wdata   = r_value;
        ram_re      = 1'b0;
        unique case (r_state)
            bst_pkg::S_IDLE: begin
                n_rd_addr = '0;
            end
            bst_pkg::S_SCAN: begin
                if (hit || !more) begin
                    n_present = hit;
                    unique case (r_op)
                        bst_pkg::OP_CLEAR: begin
                            n_status = bst_pkg::ST_DONE;
                            n_count  = '0;
                        end
                        bst_pkg::OP_ADD: begin
                            if (hit) begin
                                n_status = bst_pkg::ST_ALREADY;
                            end else if (r_count >= CW'(MAX_ELEMENTS)) begin
                                n_status = bst_pkg::ST_FULL;
                            end else begin
                                n_status = bst_pkg::ST_DONE;
                                ram_we   = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        bst_pkg::OP_REMOVE: begin
                            n_status  = hit ? bst_pkg::ST_DONE : bst_pkg::ST_NOT_FOUND;
                            n_rd_addr = r_pend_addr + 1'b1;
                        end
                        bst_pkg::OP_QUERY: begin
                            n_status = hit ? bst_pkg::ST_DONE : bst_pkg::ST_NOT_FOUND;
                        end
                        default: n_status = bst_pkg::ST_DONE;
                    endcase
                end else begin
                    // more entries to read; compare happens in the cycle after the read
                    ram_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                    n_rd_addr   = r_rd_addr + 1'b1;
                end
            end
            bst_pkg::S_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (more) begin
                    ram_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                    n_rd_addr   = r_rd_addr + 1'b1;
                end else if (!r_pend) begin
                    n_count = r_count - 1'b1;
                end
            end
            bst_pkg::S_RESP: begin
                n_rd_addr = '0;
            end
            default: n_rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bst_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (r_state == bst_pkg::S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_pend_addr <= n_pend_addr;
        r_present   <= n_present;
        r_status    <= n_status;
        if (in_fire) begin
            r_op    <= bst_pkg::t_opcode'(i_opcode);
            r_value <= i_value;
        end
        if (r_state == bst_pkg::S_RESP && out_free) begin
            r_out_present <= r_present;
            r_out_status  <= r_status;
            r_out_count   <= r_count;
        end
    end

    assign count_ext   = {8'd0, r_out_count};
    assign o_in_stall  = (r_state != bst_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_present   = r_out_present;
    assign o_status    = r_out_status;
    assign o_count     = count_ext[7:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("count above capacity");

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == bst_pkg::S_SCAN)
        else $error("accepted transaction did not start a scan");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr <= r_count) && (ram_waddr < CW'(MAX_ELEMENTS)))
        else $error("store write outside held range");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bst_pkg::S_IDLE |-> !r_pend)
        else $error("read outstanding while idle");

    a_resp_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bst_pkg::S_RESP && out_free) |=> o_out_valid)
        else $error("result not presented");

endmodule

>>> src/bst_ram.sv
// Entry store: one write port, one registered read port.
module bst_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
